@@ hdl/sgpa_pkg.sv @@
package sgpa_pkg;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFTENING = 8'd1;

    localparam logic [31:0] GRAVITY_RST   = 32'd65536;
    localparam logic [31:0] SOFTENING_RST = 32'd1;

    localparam int unsigned MAG_STAGES  = 64;   // one quotient bit of G*m / D per stage
    localparam int unsigned ROOT_STAGES = 33;   // one root bit per stage
    localparam int unsigned COMP_STAGES = 33;   // one quotient bit of mag*|d| / r per stage

    // Magnitude divide and square root run side by side in this stage type
    typedef struct packed {
        logic        zero;
        logic        negx;
        logic        negy;
        logic [32:0] ax;
        logic [32:0] ay;
        logic [63:0] dn;     // dividend shifting out, quotient shifting in
        logic [49:0] drem;
        logic [49:0] den;
        logic [65:0] ss;     // radicand, two bits consumed per stage
        logic [34:0] srem;
        logic [32:0] sq;
    } t_rt_stage;

    typedef struct packed {
        logic        zero;
        logic        negx;
        logic        negy;
        logic        ovfx;
        logic        ovfy;
        logic [32:0] root;
        logic [32:0] remx;
        logic [32:0] remy;
        logic [32:0] nx;
        logic [32:0] ny;
    } t_qt_stage;

    function automatic t_rt_stage rt_step(input t_rt_stage a, input logic do_root);
        t_rt_stage   b;
        logic [50:0] dcur;
        logic [36:0] scur;
        logic [36:0] strial;
        b    = a;
        dcur = {a.drem, a.dn[63]};
        if (dcur >= {1'b0, a.den}) begin
            b.drem = 50'(dcur - {1'b0, a.den});
            b.dn   = {a.dn[62:0], 1'b1};
        end else begin
            b.drem = dcur[49:0];
            b.dn   = {a.dn[62:0], 1'b0};
        end
        if (do_root) begin
            scur   = {a.srem, a.ss[65:64]};
            strial = {2'b00, a.sq, 2'b01};
            b.ss   = {a.ss[63:0], 2'b00};
            if (scur >= strial) begin
                b.srem = 35'(scur - strial);
                b.sq   = {a.sq[31:0], 1'b1};
            end else begin
                b.srem = scur[34:0];
                b.sq   = {a.sq[31:0], 1'b0};
            end
        end
        return b;
    endfunction

    // one restoring step of a lane: returns {rem, n}
    function automatic logic [65:0] qt_lane(input logic [32:0] rem, input logic [32:0] n,
                                            input logic [32:0] root);
        logic [33:0] cur;
        logic [65:0] res;
        cur = {rem, n[32]};
        if (cur >= {1'b0, root}) begin
            res = {33'(cur - {1'b0, root}), n[31:0], 1'b1};
        end else begin
            res = {cur[32:0], n[31:0], 1'b0};
        end
        return res;
    endfunction

    function automatic t_qt_stage qt_step(input t_qt_stage a);
        t_qt_stage   b;
        logic [65:0] lx;
        logic [65:0] ly;
        b      = a;
        lx     = qt_lane(a.remx, a.nx, a.root);
        ly     = qt_lane(a.remy, a.ny, a.root);
        b.remx = lx[65:33];
        b.nx   = lx[32:0];
        b.remy = ly[65:33];
        b.ny   = ly[32:0];
        return b;
    endfunction

    // clip a magnitude to the signed range and apply the sign; returns {sat, value}
    function automatic logic [32:0] sat_comp(input logic ovf, input logic neg,
                                             input logic [32:0] q);
        logic [32:0] limit;
        logic [32:0] v;
        logic        sat;
        limit = neg ? 33'h080000000 : 33'h07FFFFFFF;
        sat   = ovf || (q > limit);
        v     = sat ? limit : q;
        return {sat, neg ? 32'(33'd0 - v) : v[31:0]};
    endfunction

endpackage

@@ hdl/softened_gravity_pair_accel_core.sv @@
// Softened 2D gravitational acceleration of a source body on a target, signed Q16.16.
// One body pair is taken per clock while the output is not stalled; the pipeline depth
// is set by the 64-step bit-per-stage divider for G*m/D (the 33-step square root runs
// beside it) followed by the 33-step divider that scales by the true length. The whole
// pipeline holds while a result waits on i_m_axis_tready. Equal positions give zero.
// Configuration: index 0 is G (reset 1.0), index 1 is the squared softening length
// (reset 2^-16, zero behaves as 2^-16); write only while no pair is in flight.
module softened_gravity_pair_accel_core
    import sgpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // target_x, target_y, source_x, source_y, source_mass
    input  logic [159:0]         i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // accel_x, accel_y
    output logic [63:0]          o_m_axis_tdata,
    // saturated
    output logic                 o_m_axis_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    logic        ce;
    logic [31:0] r_grav;
    logic [31:0] r_soft;
    logic [31:0] soft_eff;

    logic        r1_vld, r1_zero, r1_negx, r1_negy;
    logic [32:0] r1_ax, r1_ay;
    logic [63:0] r1_gm;
    logic        r2_vld, r2_zero, r2_negx, r2_negy;
    logic [32:0] r2_ax, r2_ay;
    logic [63:0] r2_gm;
    logic [64:0] r2_sx, r2_sy;
    logic        r3_vld;
    t_rt_stage   r3_st;
    t_rt_stage   n3_st;

    logic [MAG_STAGES-1:0] r_pv;
    t_rt_stage             r_p [MAG_STAGES];

    logic        rm1_vld, rm1_zero, rm1_negx, rm1_negy;
    logic [32:0] rm1_root;
    logic [64:0] rm1_xlo, rm1_xhi, rm1_ylo, rm1_yhi;
    logic        rm2_vld, rm2_zero, rm2_negx, rm2_negy;
    logic [32:0] rm2_root;
    logic [96:0] rm2_nx, rm2_ny;
    logic        rm3_vld;
    t_qt_stage   rm3_st;
    t_qt_stage   nm3_st;

    logic [COMP_STAGES-1:0] r_qv;
    t_qt_stage              r_q [COMP_STAGES];

    logic        r_out_vld;
    logic [63:0] r_out_data;
    logic        r_out_sat;
    logic [32:0] fin_x, fin_y;

    logic signed [32:0] dx, dy;
    logic [49:0]        d2;

    assign ce              = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = ce;
    assign o_cfg_ready     = 1'b1;
    assign soft_eff        = (r_soft == 32'd0) ? 32'd1 : r_soft;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GRAVITY_RST;
            r_soft <= SOFTENING_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_GRAVITY) begin
                r_grav <= i_cfg_data;
            end else if (i_cfg_index == CFG_SOFTENING) begin
                r_soft <= i_cfg_data;
            end
        end
    end

    assign dx = 33'(signed'(i_s_axis_tdata[95:64])) - 33'(signed'(i_s_axis_tdata[31:0]));
    assign dy = 33'(signed'(i_s_axis_tdata[127:96])) - 33'(signed'(i_s_axis_tdata[63:32]));

    always_comb begin
        n3_st      = '0;
        d2         = 50'({1'b0, r2_sx} + {1'b0, r2_sy} >> 16);
        n3_st.zero = r2_zero;
        n3_st.negx = r2_negx;
        n3_st.negy = r2_negy;
        n3_st.ax   = r2_ax;
        n3_st.ay   = r2_ay;
        n3_st.dn   = r2_gm;
        n3_st.ss   = {1'b0, r2_sx} + {1'b0, r2_sy};
        n3_st.den  = (d2 > {18'd0, soft_eff}) ? d2 : {18'd0, soft_eff};
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r_pv      <= '0;
            rm1_vld   <= 1'b0;
            rm2_vld   <= 1'b0;
            rm3_vld   <= 1'b0;
            r_qv      <= '0;
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r1_vld    <= i_s_axis_tvalid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r_pv      <= {r_pv[MAG_STAGES-2:0], r3_vld};
            rm1_vld   <= r_pv[MAG_STAGES-1];
            rm2_vld   <= rm1_vld;
            rm3_vld   <= rm2_vld;
            r_qv      <= {r_qv[COMP_STAGES-2:0], rm3_vld};
            r_out_vld <= r_qv[COMP_STAGES-1];
        end
    end

    always_comb begin
        nm3_st      = '0;
        nm3_st.zero = rm2_zero;
        nm3_st.negx = rm2_negx;
        nm3_st.negy = rm2_negy;
        nm3_st.root = rm2_root;
        nm3_st.ovfx = rm2_nx[96:33] >= {31'd0, rm2_root};
        nm3_st.ovfy = rm2_ny[96:33] >= {31'd0, rm2_root};
        nm3_st.remx = rm2_nx[65:33];
        nm3_st.remy = rm2_ny[65:33];
        nm3_st.nx   = rm2_nx[32:0];
        nm3_st.ny   = rm2_ny[32:0];
    end

    assign fin_x = sat_comp(r_q[COMP_STAGES-1].ovfx, r_q[COMP_STAGES-1].negx,
                            r_q[COMP_STAGES-1].nx);
    assign fin_y = sat_comp(r_q[COMP_STAGES-1].ovfy, r_q[COMP_STAGES-1].negy,
                            r_q[COMP_STAGES-1].ny);

    // payload
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_zero <= (dx == 33'sd0) && (dy == 33'sd0);
            r1_negx <= dx[32];
            r1_negy <= dy[32];
            r1_ax   <= dx[32] ? 33'(-dx) : 33'(dx);
            r1_ay   <= dy[32] ? 33'(-dy) : 33'(dy);
            r1_gm   <= 64'(r_grav) * 64'(i_s_axis_tdata[159:128]);

            r2_zero <= r1_zero;
            r2_negx <= r1_negx;
            r2_negy <= r1_negy;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_gm   <= r1_gm;
            r2_sx   <= 65'(r1_ax) * 65'(r1_ax);
            r2_sy   <= 65'(r1_ay) * 65'(r1_ay);

            r3_st   <= n3_st;

            r_p[0] <= rt_step(r3_st, 1'b1);
            for (int k = 1; k < MAG_STAGES; k++) begin
                r_p[k] <= rt_step(r_p[k-1], k < ROOT_STAGES);
            end

            rm1_zero <= r_p[MAG_STAGES-1].zero;
            rm1_negx <= r_p[MAG_STAGES-1].negx;
            rm1_negy <= r_p[MAG_STAGES-1].negy;
            rm1_root <= r_p[MAG_STAGES-1].sq;
            rm1_xlo  <= 65'(r_p[MAG_STAGES-1].dn[31:0]) * 65'(r_p[MAG_STAGES-1].ax);
            rm1_xhi  <= 65'(r_p[MAG_STAGES-1].dn[63:32]) * 65'(r_p[MAG_STAGES-1].ax);
            rm1_ylo  <= 65'(r_p[MAG_STAGES-1].dn[31:0]) * 65'(r_p[MAG_STAGES-1].ay);
            rm1_yhi  <= 65'(r_p[MAG_STAGES-1].dn[63:32]) * 65'(r_p[MAG_STAGES-1].ay);

            rm2_zero <= rm1_zero;
            rm2_negx <= rm1_negx;
            rm2_negy <= rm1_negy;
            rm2_root <= rm1_root;
            rm2_nx   <= {rm1_xhi, 32'd0} + 97'(rm1_xlo);
            rm2_ny   <= {rm1_yhi, 32'd0} + 97'(rm1_ylo);

            rm3_st   <= nm3_st;

            r_q[0] <= qt_step(rm3_st);
            for (int k = 1; k < COMP_STAGES; k++) begin
                r_q[k] <= qt_step(r_q[k-1]);
            end

            if (r_q[COMP_STAGES-1].zero) begin
                r_out_data <= '0;
                r_out_sat  <= 1'b0;
            end else begin
                r_out_data <= {fin_y[31:0], fin_x[31:0]};
                r_out_sat  <= fin_x[32] | fin_y[32];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_sat;

endmodule
